@@ design/lpgd_pkg.sv @@
// types and constants shared by the lidar point gate and decimator
`timescale 1ns / 1ps

package lpgd_pkg;

    // field widths
    localparam int COORD_BITS     = 20;
    localparam int RANGE_BITS     = 20;
    localparam int KEEP_BITS      = 8;
    localparam int BYTE_BITS      = 8;
    localparam int NS_BITS        = 32;
    localparam int TIME_BITS      = 23;
    localparam int CFG_IDX_BITS   = 2;

    // derived arithmetic widths
    localparam int SQ_BITS        = 2 * COORD_BITS;
    localparam int SUM_BITS       = SQ_BITS + 2;
    localparam int RANGE_SQ_BITS  = 2 * RANGE_BITS;
    localparam int CMP_BITS       = (SUM_BITS > RANGE_SQ_BITS) ? SUM_BITS : RANGE_SQ_BITS;

    // configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_KEEP_EVERY = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MIN_RANGE  = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MAX_RANGE  = 2'd2;

    // configuration reset values
    localparam logic [KEEP_BITS-1:0]     KEEP_EVERY_RESET = 8'd1;
    localparam logic [RANGE_BITS-1:0]    MIN_RANGE_RESET  = 20'd500;
    localparam logic [RANGE_BITS-1:0]    MAX_RANGE_RESET  = 20'hFFFFF;
    localparam logic [RANGE_SQ_BITS-1:0] MIN_SQ_RESET     =
        RANGE_SQ_BITS'(MIN_RANGE_RESET) * RANGE_SQ_BITS'(MIN_RANGE_RESET);
    localparam logic [RANGE_SQ_BITS-1:0] MAX_SQ_RESET     =
        RANGE_SQ_BITS'(MAX_RANGE_RESET) * RANGE_SQ_BITS'(MAX_RANGE_RESET);

    // point qualification
    localparam logic [BYTE_BITS-1:0] LINE_LIMIT     = 8'd4;
    localparam int                   TAG_REJECT_BIT = 5;

    // ns to ms q10: floor(ns * 1024 / 1e6) = floor(ns * 16 / 15625)
    localparam int NS_PER_MS        = 1000000;
    localparam int TIME_FRAC_BITS   = 10;
    localparam int TIME_PRE_SHIFT   = 4;
    localparam int TIME_DIV         = NS_PER_MS >> (TIME_FRAC_BITS - TIME_PRE_SHIFT);
    localparam int TIME_RECIP_SHIFT = 41;
    localparam int RECIP_BITS       = 32;
    localparam int PROD_BITS        = NS_BITS + RECIP_BITS;
    localparam int NUM_BITS         = NS_BITS + TIME_PRE_SHIFT;
    localparam logic [RECIP_BITS-1:0] TIME_RECIP =
        RECIP_BITS'((64'd1 << (TIME_RECIP_SHIFT + TIME_PRE_SHIFT)) / 64'(TIME_DIV));

    // input beat
    typedef struct packed {
        logic                         frame_start;
        logic signed [COORD_BITS-1:0] x_mm;
        logic signed [COORD_BITS-1:0] y_mm;
        logic signed [COORD_BITS-1:0] z_mm;
        logic [BYTE_BITS-1:0]         reflect;
        logic [BYTE_BITS-1:0]         tag_bits;
        logic [BYTE_BITS-1:0]         laser_line;
        logic [NS_BITS-1:0]           offset_ns;
    } point_in_t;

    // output beat
    typedef struct packed {
        logic signed [COORD_BITS-1:0] x_out;
        logic signed [COORD_BITS-1:0] y_out;
        logic signed [COORD_BITS-1:0] z_out;
        logic [BYTE_BITS-1:0]         intensity;
        logic [TIME_BITS-1:0]         time_ms_q10;
    } point_out_t;

endpackage

@@ design/lidar_point_gate_decimate.sv @@
// top level of the lidar point gate, decimator and range window
`timescale 1ns / 1ps

// Lidar point gate: takes one point beat per cycle while in_ready is high and emits
// a point when its laser line is below 4, tag bit 5 is clear, it is the first of each
// keep_every qualifying points (counter cleared by frame_start), and its squared range
// lies strictly between min_range_mm^2 and max_range_mm^2. Throughput is one point per
// clock while out_ready does not stall the pipeline; a result passes through three
// register stages (gate register, coordinate-square and time-reciprocal multiplier
// register, window compare and time correction output register). Backpressure on
// out_ready stalls the pipeline stage by stage, so in_ready stays high while any stage
// is free. Configuration writes are taken every cycle (cfg_ready is always high);
// range registers are squared as they are written.
module lidar_point_gate_decimate
    import lpgd_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  point_in_t               in_data,
    output logic                    out_valid,
    input  logic                    out_ready,
    output point_out_t              out_data,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [CFG_IDX_BITS-1:0] cfg_index,
    input  logic [RANGE_BITS-1:0]   cfg_data
);

    // configuration registers
    logic [KEEP_BITS-1:0]     keep_every_reg;
    logic [RANGE_SQ_BITS-1:0] min_sq_reg;
    logic [RANGE_SQ_BITS-1:0] max_sq_reg;
    logic [RANGE_SQ_BITS-1:0] cfg_sq;

    // decimation counter
    logic [KEEP_BITS-1:0] count_reg;
    logic [KEEP_BITS-1:0] count_next;
    logic [KEEP_BITS-1:0] count_eff;
    logic [KEEP_BITS-1:0] factor;
    logic [KEEP_BITS:0]   count_inc;
    logic                 qualify;
    logic                 keep_now;
    logic                 in_fire;

    // pipeline control
    logic load1;
    logic load2;
    logic load3;

    // stage 1
    logic      s1_valid_reg;
    point_in_t s1_data_reg;

    // stage 2
    logic                         s2_valid_reg;
    logic [SQ_BITS-1:0]           x_sq_reg;
    logic [SQ_BITS-1:0]           y_sq_reg;
    logic [SQ_BITS-1:0]           z_sq_reg;
    logic signed [COORD_BITS-1:0] s2_x_reg;
    logic signed [COORD_BITS-1:0] s2_y_reg;
    logic signed [COORD_BITS-1:0] s2_z_reg;
    logic [BYTE_BITS-1:0]         s2_reflect_reg;
    logic [NS_BITS-1:0]           s2_ns_reg;
    logic [TIME_BITS-1:0]         q0_reg;

    // stage 2 inputs
    logic [COORD_BITS-1:0] ax;
    logic [COORD_BITS-1:0] ay;
    logic [COORD_BITS-1:0] az;
    logic [PROD_BITS-1:0]  time_prod;

    // stage 3 logic
    logic [CMP_BITS-1:0]  sq_sum;
    logic                 in_window;
    logic [NUM_BITS-1:0]  time_num;
    logic [NUM_BITS-1:0]  q0_back;
    logic [NUM_BITS-1:0]  time_rem;
    logic [TIME_BITS-1:0] time_q;

    // output register
    logic       out_valid_reg;
    point_out_t out_data_reg;

    // configuration writes, range squared on the way in
    assign cfg_ready = 1'b1;
    assign cfg_sq    = cfg_data * cfg_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            keep_every_reg <= KEEP_EVERY_RESET;
            min_sq_reg     <= MIN_SQ_RESET;
            max_sq_reg     <= MAX_SQ_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_KEEP_EVERY: keep_every_reg <= cfg_data[KEEP_BITS-1:0];
                CFG_MIN_RANGE:  min_sq_reg     <= cfg_sq;
                CFG_MAX_RANGE:  max_sq_reg     <= cfg_sq;
                default:        ;
            endcase
        end
    end

    // backpressure chain, each stage loads when empty or draining
    assign load3    = !out_valid_reg || out_ready;
    assign load2    = !s2_valid_reg || load3;
    assign load1    = !s1_valid_reg || load2;
    assign in_ready = load1;
    assign in_fire  = in_valid && in_ready;

    // gate and decimation decision on the incoming beat
    always_comb
    begin
        qualify    = (in_data.laser_line < LINE_LIMIT) && !in_data.tag_bits[TAG_REJECT_BIT];
        factor     = (keep_every_reg == '0) ? KEEP_BITS'(1) : keep_every_reg;
        count_eff  = in_data.frame_start ? '0 : count_reg;
        count_inc  = {1'b0, count_eff} + 1'b1;
        keep_now   = qualify && (count_eff == '0);
        count_next = count_eff;
        if (qualify)
        begin
            count_next = (count_inc >= {1'b0, factor}) ? '0 : count_inc[KEEP_BITS-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (in_fire)
        begin
            count_reg <= count_next;
        end
    end

    // stage 1: hold kept points only
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (load1)
        begin
            s1_valid_reg <= in_fire && keep_now;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_data_reg <= in_data;
        end
    end

    // stage 2 inputs: coordinate magnitudes and time reciprocal product
    always_comb
    begin
        ax = s1_data_reg.x_mm[COORD_BITS-1] ? (~s1_data_reg.x_mm + 1'b1) : s1_data_reg.x_mm;
        ay = s1_data_reg.y_mm[COORD_BITS-1] ? (~s1_data_reg.y_mm + 1'b1) : s1_data_reg.y_mm;
        az = s1_data_reg.z_mm[COORD_BITS-1] ? (~s1_data_reg.z_mm + 1'b1) : s1_data_reg.z_mm;
        time_prod = PROD_BITS'(s1_data_reg.offset_ns) * PROD_BITS'(TIME_RECIP);
    end

    // stage 2: squares and time estimate
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (load2)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load2 && s1_valid_reg)
        begin
            x_sq_reg       <= ax * ax;
            y_sq_reg       <= ay * ay;
            z_sq_reg       <= az * az;
            s2_x_reg       <= s1_data_reg.x_mm;
            s2_y_reg       <= s1_data_reg.y_mm;
            s2_z_reg       <= s1_data_reg.z_mm;
            s2_reflect_reg <= s1_data_reg.reflect;
            s2_ns_reg      <= s1_data_reg.offset_ns;
            q0_reg         <= time_prod[TIME_RECIP_SHIFT +: TIME_BITS];
        end
    end

    // stage 3 logic: range window and one-step quotient correction
    always_comb
    begin
        sq_sum    = CMP_BITS'(x_sq_reg) + CMP_BITS'(y_sq_reg) + CMP_BITS'(z_sq_reg);
        in_window = (sq_sum > CMP_BITS'(min_sq_reg)) && (sq_sum < CMP_BITS'(max_sq_reg));
        time_num  = {s2_ns_reg, {TIME_PRE_SHIFT{1'b0}}};
        q0_back   = NUM_BITS'(q0_reg) * NUM_BITS'(TIME_DIV);
        time_rem  = time_num - q0_back;
        time_q    = (time_rem >= NUM_BITS'(TIME_DIV)) ? (q0_reg + 1'b1) : q0_reg;
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load3)
        begin
            out_valid_reg <= s2_valid_reg && in_window;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load3 && s2_valid_reg)
        begin
            out_data_reg.x_out       <= s2_x_reg;
            out_data_reg.y_out       <= s2_y_reg;
            out_data_reg.z_out       <= s2_z_reg;
            out_data_reg.intensity   <= s2_reflect_reg;
            out_data_reg.time_ms_q10 <= time_q;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // a qualifying beat at frame start is always kept
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && in_data.frame_start && qualify) |=> s1_valid_reg)
    else $error("frame start point was decimated");

    // reciprocal estimate is never more than one below the quotient
    assert property (@(posedge clk) disable iff (!rst_n)
        s2_valid_reg |-> (time_rem < NUM_BITS'(2 * TIME_DIV)))
    else $error("time quotient estimate out of correction range");

    // a stalled stage 2 beat is not overwritten
    assert property (@(posedge clk) disable iff (!rst_n)
        (s2_valid_reg && !load3) |=> (s2_valid_reg && $stable(q0_reg) && $stable(s2_x_reg)))
    else $error("stage 2 beat lost under stall");

    // input is held off only while stage 1 is occupied
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> s1_valid_reg)
    else $error("input stalled with empty pipeline front");

endmodule

@@ bench/tb_lidar_point_gate_decimate.sv @@
// testbench for the lidar point gate with decimation and range window
`timescale 1ns / 1ps

module tb_lidar_point_gate_decimate;
    import lpgd_pkg::*;

    // index past the last register, writes to it must be dropped
    localparam logic [CFG_IDX_BITS-1:0] CFG_UNUSED = 2'd3;

    localparam int SETTLE_CYCLES = 8;
    localparam int MAX_IDLE      = 14;
    localparam int CALM_SPAN     = 40;
    localparam int TIMEOUT_NS    = 1_000_000;
    localparam int NUM_PHASES    = 8;

    // directed row: beat plus an optional typed-in expectation
    typedef struct packed {
        point_in_t            pt;
        bit                   typed;
        bit                   yields;
        logic [TIME_BITS-1:0] t_ms;
    } probe_row_t;

    // one register setting and the random traffic run under it
    typedef struct packed {
        logic [RANGE_BITS-1:0] keep_raw;
        logic [RANGE_BITS-1:0] min_mm;
        logic [RANGE_BITS-1:0] max_mm;
        int                    span;
        int                    count;
        int                    fs_odds;
        bit                    poke_unused;
    } phase_t;

    logic                    clk = 1'b0;
    logic                    rst_n;
    logic                    in_valid;
    logic                    in_ready;
    point_in_t               in_data;
    logic                    out_valid;
    logic                    out_ready;
    point_out_t              out_data;
    logic                    cfg_valid;
    logic                    cfg_ready;
    logic [CFG_IDX_BITS-1:0] cfg_index;
    logic [RANGE_BITS-1:0]   cfg_data;

    // predictor copy of the registers and decimation counter
    logic [KEEP_BITS-1:0]  keep_every_r;
    logic [RANGE_BITS-1:0] min_range_r;
    logic [RANGE_BITS-1:0] max_range_r;
    logic [KEEP_BITS-1:0]  decim_count;

    point_out_t pending_points[$];
    probe_row_t probe_rows[$];
    phase_t     phases[NUM_PHASES];
    int         bad_points = 0;
    int         beats_sent = 0;
    bit         send_calm  = 1'b0;
    bit         sink_calm  = 1'b0;

    lidar_point_gate_decimate DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // 2 ns clock
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic int draw_gap(input bit calm);
        if (calm)
            return 0;
        return $urandom_range(0, MAX_IDLE);
    endfunction

    function automatic longint unsigned coord_sq(input logic signed [COORD_BITS-1:0] c);
        longint signed v;
        v = c;
        if (v < 0)
            v = -v;
        return v * v;
    endfunction

    // register write as the block sees it
    function automatic void apply_register(input logic [CFG_IDX_BITS-1:0] idx,
                                           input logic [RANGE_BITS-1:0] val);
        case (idx)
            CFG_KEEP_EVERY: keep_every_r = val[KEEP_BITS-1:0];
            CFG_MIN_RANGE:  min_range_r  = val;
            CFG_MAX_RANGE:  max_range_r  = val;
            default:        ;
        endcase
    endfunction

    // gate, decimate and range-window one point; 1 when a point comes out
    function automatic bit gate_point(input point_in_t p, output point_out_t r);
        logic [KEEP_BITS-1:0] factor;
        bit                   keep;
        int unsigned          next_cnt;
        longint unsigned      dist_sq;
        longint unsigned      lo_sq;
        longint unsigned      hi_sq;
        longint unsigned      ns_q;
        r = '0;
        if (p.frame_start)
            decim_count = '0;
        if (p.laser_line >= LINE_LIMIT || p.tag_bits[TAG_REJECT_BIT])
            return 1'b0;
        // zero factor behaves as one
        factor = (keep_every_r == '0) ? 8'd1 : keep_every_r;
        keep = (decim_count == '0);
        next_cnt = decim_count + 1;
        decim_count = (next_cnt >= factor) ? '0 : next_cnt[KEEP_BITS-1:0];
        if (!keep)
            return 1'b0;
        dist_sq = coord_sq(p.x_mm) + coord_sq(p.y_mm) + coord_sq(p.z_mm);
        lo_sq = longint'(min_range_r) * longint'(min_range_r);
        hi_sq = longint'(max_range_r) * longint'(max_range_r);
        if (!(dist_sq > lo_sq && dist_sq < hi_sq))
            return 1'b0;
        ns_q = p.offset_ns;
        ns_q = (ns_q << TIME_FRAC_BITS) / NS_PER_MS;
        r.x_out       = p.x_mm;
        r.y_out       = p.y_mm;
        r.z_out       = p.z_mm;
        r.intensity   = p.reflect;
        r.time_ms_q10 = ns_q[TIME_BITS-1:0];
        return 1'b1;
    endfunction

    function automatic point_in_t make_point(input bit fs, input int x, input int y,
                                             input int z, input int refl, input int tag,
                                             input int line, input logic [NS_BITS-1:0] ns);
        point_in_t p;
        p.frame_start = fs;
        p.x_mm        = x[COORD_BITS-1:0];
        p.y_mm        = y[COORD_BITS-1:0];
        p.z_mm        = z[COORD_BITS-1:0];
        p.reflect     = refl[BYTE_BITS-1:0];
        p.tag_bits    = tag[BYTE_BITS-1:0];
        p.laser_line  = line[BYTE_BITS-1:0];
        p.offset_ns   = ns;
        return p;
    endfunction

    function automatic void add_probe(input bit fs, input int x, input int y, input int z,
                                      input int refl, input int tag, input int line,
                                      input logic [NS_BITS-1:0] ns, input bit typed,
                                      input bit yields, input int t);
        probe_row_t row;
        row.pt     = make_point(fs, x, y, z, refl, tag, line, ns);
        row.typed  = typed;
        row.yields = yields;
        row.t_ms   = t[TIME_BITS-1:0];
        probe_rows.insert(probe_rows.size(), row);
    endfunction

    // random coordinate: extremes, near the window, or anywhere
    function automatic int pick_coord(input int span);
        int pick;
        pick = $urandom_range(0, 19);
        if (pick < 2)
        begin
            case ($urandom_range(0, 4))
                0:       return -524288;
                1:       return 524287;
                2:       return 0;
                3:       return -1;
                default: return 1;
            endcase
        end
        if (span == 0 || pick < 5)
            return int'($urandom);
        return int'($urandom_range(0, 2 * span)) - span;
    endfunction

    // send one point beat; the expectation is taken at the accepting edge
    task automatic push_point(input point_in_t p, input bit typed, input bit yields,
                              input logic [TIME_BITS-1:0] t_ms);
        int         gap;
        point_out_t want;
        bit         hit;
        if (beats_sent % CALM_SPAN == 0)
            send_calm = ($urandom_range(0, 2) == 0);
        beats_sent++;
        gap = draw_gap(send_calm);
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_data  = p;
        in_valid = 1'b1;
        do @(posedge clk); while (in_ready !== 1'b1);
        hit = gate_point(p, want);
        if (typed)
        begin
            hit = yields;
            want.x_out       = p.x_mm;
            want.y_out       = p.y_mm;
            want.z_out       = p.z_mm;
            want.intensity   = p.reflect;
            want.time_ms_q10 = t_ms;
        end
        if (hit)
            pending_points.insert(pending_points.size(), want);
        @(negedge clk);
    endtask

    // stop sending and let every expected point and trailing beat drain
    task automatic settle();
        in_valid = 1'b0;
        while (pending_points.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // leaves cfg_valid high, caller lowers it after the last write
    task automatic write_register(input logic [CFG_IDX_BITS-1:0] idx,
                                  input logic [RANGE_BITS-1:0] val);
        cfg_index = idx;
        cfg_data  = val;
        cfg_valid = 1'b1;
        do @(posedge clk); while (cfg_ready !== 1'b1);
        apply_register(idx, val);
        @(negedge clk);
    endtask

    // result sink pacing
    initial
    begin : sink_pacing
        int hold;
        int taken;
        taken = 0;
        out_ready = 1'b0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever
        begin
            if (taken % CALM_SPAN == 0)
                sink_calm = ($urandom_range(0, 2) == 0);
            taken++;
            hold = draw_gap(sink_calm);
            if (hold > 0)
            begin
                out_ready = 1'b0;
                repeat (hold) @(negedge clk);
            end
            out_ready = 1'b1;
            do @(posedge clk); while (out_valid !== 1'b1);
            @(negedge clk);
        end
    end

    // compare each result beat with the oldest expected point
    always @(posedge clk)
    begin
        point_out_t want;
        if (rst_n === 1'b1 && out_valid === 1'b1 && out_ready === 1'b1)
        begin
            if (pending_points.size() == 0)
            begin
                bad_points++;
                $display("%0t: unexpected point, expected none, got %h", $time, out_data);
            end
            else
            begin
                want = pending_points.pop_front();
                if (out_data !== want)
                begin
                    bad_points++;
                    $display("%0t: point mismatch, expected %h, got %h",
                             $time, want, out_data);
                end
            end
        end
    end

    // hard stop
    initial
    begin
        #(TIMEOUT_NS);
        $display("TB_ERROR");
        $finish;
    end

    initial
    begin : stimulus
        point_in_t pt;
        phase_t    ph;
        bit        fs;
        bit        tidy;
        int        line;
        int        tag;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_data   = '0;
        cfg_valid = 1'b0;
        cfg_index = CFG_KEEP_EVERY;
        cfg_data  = '0;

        keep_every_r = KEEP_EVERY_RESET;
        min_range_r  = MIN_RANGE_RESET;
        max_range_r  = MAX_RANGE_RESET;
        decim_count  = '0;

        // directed rows under reset settings: every point kept, window 500 .. 1048575 mm
        add_probe(1, 1000, 0, 0, 'hA5, 'h00, 0, 32'd1000000, 1, 1, 1024);
        add_probe(0, -524288, -524288, -524288, 'hFF, 'hDF, 3, 32'hFFFFFFFF, 1, 1, 4398046);
        add_probe(0, 524287, 524287, 524287, 'h00, 'h00, 3, 32'd0, 1, 1, 0);
        // bad laser line or unreliable tag
        add_probe(0, 1000, 0, 0, 'h11, 'h00, 4, 32'd5, 1, 0, 0);
        add_probe(0, 1000, 0, 0, 'h11, 'h00, 255, 32'd5, 1, 0, 0);
        add_probe(0, 1000, 0, 0, 'h22, 'h20, 0, 32'd5, 1, 0, 0);
        add_probe(0, 1000, 0, 0, 'h22, 'hFF, 1, 32'd5, 1, 0, 0);
        // range exactly at the lower bound, then just past it
        add_probe(0, 500, 0, 0, 'h33, 'h00, 0, 32'd976, 1, 0, 0);
        add_probe(0, 0, -501, 0, 'h44, 'h00, 1, 32'd977, 1, 1, 1);
        add_probe(0, 0, 0, 0, 'h55, 'h00, 2, 32'd100, 1, 0, 0);
        add_probe(0, 300, 400, 0, 'h66, 'h00, 2, 32'd100, 1, 0, 0);
        add_probe(0, 300, 400, 1, 'h77, 'h00, 3, 32'd999999, 1, 1, 1023);
        add_probe(0, -1, -1, -1, 'h88, 'h00, 0, 32'd1, 1, 0, 0);
        add_probe(1, 0, 0, 600, 'h5A, 'h10, 2, 32'd2000000, 1, 1, 2048);
        add_probe(0, 123456, -234567, 345678, 'h3C, 'h01, 1, 32'd123456789, 0, 0, 0);
        add_probe(1, -77777, 88888, -99999, 'hC3, 'h80, 2, 32'hDEADBEEF, 0, 0, 0);

        // keep, min, max, coordinate span, beats, frame start odds, stray index write
        phases[0] = '{20'd3, 20'd1000, 20'd3000, 2500, 150, 30, 1'b0};
        phases[1] = '{20'hFFF00, 20'd100, 20'd600000, 400000, 150, 20, 1'b1};
        phases[2] = '{20'd255, 20'd0, 20'hFFFFF, 0, 150, 500, 1'b0};
        phases[3] = '{20'd2, 20'd2000, 20'd2000, 2500, 80, 500, 1'b0};
        phases[4] = '{20'd5, 20'hFFFFF, 20'd0, 0, 60, 20, 1'b1};
        phases[5] = '{20'd1, 20'd0, 20'd0, 50, 40, 10, 1'b0};
        phases[6] = '{20'd1, 20'd0, 20'hFFFFF, 0, 150, 25, 1'b0};
        phases[7] = '{20'hABC04, 20'd200, 20'd100000, 80000, 250, 40, 1'b1};

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (probe_rows[r])
            push_point(probe_rows[r].pt, probe_rows[r].typed, probe_rows[r].yields,
                       probe_rows[r].t_ms);

        for (int k = 0; k < NUM_PHASES; k++)
        begin
            ph = phases[k];
            settle();
            write_register(CFG_KEEP_EVERY, ph.keep_raw);
            write_register(CFG_MIN_RANGE, ph.min_mm);
            write_register(CFG_MAX_RANGE, ph.max_mm);
            if (ph.poke_unused)
                write_register(CFG_UNUSED, RANGE_BITS'($urandom));
            cfg_valid = 1'b0;

            for (int i = 0; i < ph.count; i++)
            begin
                // hold the stream until the block has emptied
                if (i == ph.count / 2)
                    settle();
                fs   = ($urandom_range(0, ph.fs_odds - 1) == 0);
                tidy = ($urandom_range(0, 4) != 0);
                if (tidy)
                begin
                    line = $urandom_range(0, 3);
                    tag  = $urandom_range(0, 255) & ~(1 << TAG_REJECT_BIT);
                end
                else
                begin
                    line = $urandom_range(0, 255);
                    tag  = $urandom_range(0, 255);
                end
                pt = make_point(fs, pick_coord(ph.span), pick_coord(ph.span),
                                pick_coord(ph.span), $urandom_range(0, 255), tag, line,
                                $urandom);
                push_point(pt, 1'b0, 1'b0, '0);
            end
        end

        settle();
        if (bad_points == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
